// File: rtl/bfsa_pkg.sv
// bfsa_pkg: constants, command/status/state codes and word helpers for the
// bitmap free-symbol allocator. No dependencies.
package bfsa_pkg;

  localparam int CAPACITY  = 1024;
  localparam int WORD_BITS = 64;
  localparam int NWORDS    = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int MAP_BITS  = NWORDS * WORD_BITS;
  localparam int IDX_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int LEN_W     = 11;
  localparam int SYM_W     = 10;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]     widx_t;
  typedef logic [BIT_W-1:0]     bidx_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [SYM_W-1:0]     sym_t;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_MERGE  = 3'd1,
    CMD_MDONE  = 3'd2,
    CMD_COMMIT = 3'd3,
    CMD_ALLOC  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_REUSE = 2'd1,
    STAT_FRESH = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MDONE,
    S_COMMIT,
    S_SCAN
  } state_t;

  // Bits of word w whose symbol position lies below n.
  function automatic word_t below_mask(widx_t w, len_t n);
    logic [LEN_W:0] lo;
    logic [LEN_W:0] diff;
    word_t          m;
    lo   = (LEN_W+1)'(w) << BIT_W;
    diff = {1'b0, n} - lo;
    if ({1'b0, n} <= lo) begin
      m = '0;
    end else if (diff >= (LEN_W+1)'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = (word_t'(1) << diff[BIT_W-1:0]) - word_t'(1);
    end
    return m;
  endfunction

  // Index of the lowest set bit: isolate it, then OR-encode the one-hot.
  function automatic bidx_t low_bit(word_t v);
    word_t iso;
    bidx_t idx;
    iso = v & (~v + word_t'(1));
    idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      idx = idx | (iso[b] ? bidx_t'(b) : bidx_t'(0));
    end
    return idx;
  endfunction

endpackage

// File: rtl/bitmap_free_symbol_allocator_core.sv
// bitmap_free_symbol_allocator_core: merges symbol bitmaps, builds the free
// map and hands out reused or fresh symbol indices.
// Depends on bfsa_pkg.
//
// The result transaction is registered and shows in the cycle after the
// input transaction. Clear, merge word and fresh/full allocate complete on
// acceptance. Merge done and commit sweep all NWORDS (16) map words through
// one word unit, one word a cycle. A reusing allocate does no scan when the
// pointer sits on the top symbol, else it scans forward from the old pointer
// one word a cycle until it finds a free bit or passes the last word.
// Reset (rst, synchronous): intersect map to ones, union/free maps to zero,
// length, counts and pointer to zero, no result pending.
module bitmap_free_symbol_allocator_core
  import bfsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // word_index[3:0], bitmap_word[67:4],
                                      // bitmap_length[78:68], zero pad
  input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // symbol[9:0], zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam widx_t LAST_WORD = widx_t'(NWORDS - 1);

  // Per-word maps; each is read and written at one index per cycle, but clear and reset write every word.
  word_t intersect_map [NWORDS];
  word_t union_map     [NWORDS];
  word_t free_map      [NWORDS];

  len_t    tracked_length;
  len_t    issued_count;
  sym_t    next_free;
  logic    next_free_valid;

  state_t  state, state_next;
  widx_t   wptr;        // sweep / scan word pointer
  len_t    mlim;        // intersect limit held for the merge-done sweep
  bidx_t   start_bit;   // first-word bit offset for the scan
  logic    first;       // scan is on its first word
  logic    found;       // commit sweep has seen a free bit
  sym_t    found_pos;

  logic    out_valid;
  sym_t    out_sym;
  status_t out_status;

  // Input fields
  logic [2:0] in_cmd;
  widx_t      in_widx;
  word_t      in_word;
  len_t       in_len;

  assign in_cmd  = s_axis_tuser;
  assign in_widx = s_axis_tdata[3:0];
  assign in_word = s_axis_tdata[67:4];
  assign in_len  = s_axis_tdata[78:68];

  logic accept;
  assign s_axis_tready = (state == S_IDLE) && (!out_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Shared read index: sweep pointer when busy, else the merge command's word or the fresh symbol's word.
  widx_t rd_idx;
  word_t inter_rd, union_rd, free_rd;

  always_comb begin
    if (state != S_IDLE) begin
      rd_idx = wptr;
    end else if (cmd_t'(in_cmd) == CMD_MERGE) begin
      rd_idx = in_widx;
    end else begin
      rd_idx = tracked_length[BIT_W +: IDX_W];
    end
  end

  assign inter_rd = intersect_map[rd_idx];
  assign union_rd = union_map[rd_idx];
  assign free_rd  = free_map[rd_idx];

  // Merge done: clamp the length, cut the intersect at min(len, tracked)
  len_t len_clamped, lim;
  assign len_clamped = (in_len > len_t'(CAPACITY)) ? len_t'(CAPACITY) : in_len;
  assign lim         = (len_clamped < tracked_length) ? len_clamped : tracked_length;

  // Allocate: next scan start after a reuse
  len_t  scan_start;
  logic  scan_over;
  logic  has_room;
  assign scan_start = len_t'(next_free) + len_t'(1);
  assign scan_over  = scan_start >= len_t'(MAP_BITS);
  assign has_room   = tracked_length < len_t'(CAPACITY);

  // Commit word unit: free word and its lowest set bit
  word_t commit_word;
  logic  commit_hit;
  sym_t  commit_pos;
  assign commit_word = (inter_rd | ~union_rd) & below_mask(wptr, tracked_length);
  assign commit_hit  = !found && (commit_word != '0);
  assign commit_pos  = sym_t'({wptr, low_bit(commit_word)});

  // Scan word unit: free word masked below the start on the first word
  word_t scan_word;
  logic  scan_hit;
  sym_t  scan_pos;
  assign scan_word = first ? (free_rd & ~((word_t'(1) << start_bit) - word_t'(1)))
                           : free_rd;
  assign scan_hit  = scan_word != '0;
  assign scan_pos  = sym_t'({wptr, low_bit(scan_word)});

  // Result of the accepted command, known at acceptance
  sym_t    resp_sym;
  status_t resp_status;

  always_comb begin
    resp_sym    = '0;
    resp_status = STAT_DONE;
    if (cmd_t'(in_cmd) == CMD_ALLOC) begin
      if (next_free_valid) begin
        resp_sym    = next_free;
        resp_status = STAT_REUSE;
      end else if (has_room) begin
        resp_sym    = tracked_length[SYM_W-1:0];
        resp_status = STAT_FRESH;
      end else begin
        resp_status = STAT_FULL;
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority case (cmd_t'(in_cmd))
            CMD_MDONE:  state_next = S_MDONE;
            CMD_COMMIT: state_next = S_COMMIT;
            CMD_ALLOC: begin
              if (next_free_valid && !scan_over) state_next = S_SCAN;
            end
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_MDONE, S_COMMIT: begin
        if (wptr == LAST_WORD) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (scan_hit || wptr == LAST_WORD) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NWORDS; i++) begin
        intersect_map[i] <= '1;
        union_map[i]     <= '0;
        free_map[i]      <= '0;
      end
      tracked_length  <= '0;
      issued_count    <= '0;
      next_free       <= '0;
      next_free_valid <= 1'b0;
      out_valid       <= 1'b0;
      wptr            <= '0;
      first           <= 1'b0;
      found           <= 1'b0;
      found_pos       <= '0;
      mlim            <= '0;
      start_bit       <= '0;
      out_sym         <= '0;
      out_status      <= STAT_DONE;
    end else begin
      if (!accept && m_axis_tready) out_valid <= 1'b0;

      if (accept) begin
        out_valid  <= 1'b1;
        out_sym    <= resp_sym;
        out_status <= resp_status;
        unique case (cmd_t'(in_cmd))
          CMD_CLEAR: begin
            for (int i = 0; i < NWORDS; i++) begin
              intersect_map[i] <= '1;
              union_map[i]     <= '0;
              free_map[i]      <= '0;
            end
          end
          CMD_MERGE: begin
            if (int'(in_widx) < NWORDS) begin
              intersect_map[rd_idx] <= inter_rd & in_word;
              union_map[rd_idx]     <= union_rd | in_word;
            end
          end
          CMD_MDONE: begin
            mlim <= lim;
            wptr <= '0;
            if (len_clamped > tracked_length) tracked_length <= len_clamped;
          end
          CMD_COMMIT: begin
            wptr      <= '0;
            found     <= 1'b0;
            found_pos <= '0;
          end
          CMD_ALLOC: begin
            if (next_free_valid) begin
              if (scan_over) begin
                next_free_valid <= 1'b0;
                next_free       <= '0;
              end else begin
                wptr      <= scan_start[BIT_W +: IDX_W];
                start_bit <= scan_start[BIT_W-1:0];
                first     <= 1'b1;
              end
            end else if (has_room) begin
              // fresh symbol: clear its bit in all maps
              intersect_map[rd_idx] <= inter_rd & ~(word_t'(1) << tracked_length[BIT_W-1:0]);
              union_map[rd_idx]     <= union_rd & ~(word_t'(1) << tracked_length[BIT_W-1:0]);
              free_map[rd_idx]      <= free_rd  & ~(word_t'(1) << tracked_length[BIT_W-1:0]);
              tracked_length        <= tracked_length + len_t'(1);
              if (issued_count < len_t'(CAPACITY)) issued_count <= issued_count + len_t'(1);
            end
          end
          default: ;
        endcase
      end

      unique case (state)
        S_MDONE: begin
          intersect_map[wptr] <= inter_rd & below_mask(wptr, mlim);
          wptr                <= wptr + widx_t'(1);
        end
        S_COMMIT: begin
          free_map[wptr] <= commit_word;
          wptr           <= wptr + widx_t'(1);
          if (commit_hit) begin
            found     <= 1'b1;
            found_pos <= commit_pos;
          end
          if (wptr == LAST_WORD) begin
            next_free_valid <= found || commit_hit;
            next_free       <= found ? found_pos : (commit_hit ? commit_pos : sym_t'(0));
          end
        end
        S_SCAN: begin
          first <= 1'b0;
          wptr  <= wptr + widx_t'(1);
          if (scan_hit) begin
            next_free_valid <= 1'b1;
            next_free       <= scan_pos;
          end else if (wptr == LAST_WORD) begin
            next_free_valid <= 1'b0;
            next_free       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_sym};
  assign m_axis_tuser  = out_status;

endmodule

// File: rtl/bfsa_checker.sv
// bfsa_checker: port-level assertions for the allocator core, attached by bind.
// Depends on bfsa_pkg and bitmap_free_symbol_allocator_core.
module bfsa_checker
  import bfsa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [79:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // every accepted transaction leaves a result behind it
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("no result after input transaction");

  // a result appears only after an input transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without input transaction");

  // no input taken while an undrained result would be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted over a pending result");

  // only reuse and fresh results carry a symbol
  a_sym_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == STAT_DONE || m_axis_tuser == STAT_FULL)
      |-> m_axis_tdata == 16'd0)
    else $error("symbol set on a result without allocation");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind bitmap_free_symbol_allocator_core bfsa_checker u_bfsa_checker (.*);
